/* hw/rtl/rbk_pkg.sv */
package rbk_pkg;

  // Default width of a binary angle input; half a turn is 2^(ANGLE_BITS-1).
  localparam int ANGLE_BITS_DEF = 16;

  // CORDIC rotation steps and the start vector length in Q2.30.
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Quotient bits resolved by the divider; larger quotients saturate anyway.
  localparam int DIV_BITS = 34;
  localparam int REM_W = 67;
  localparam int DEN_W = 33;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               neg;
  } cord_t;

  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] w;
    logic signed [31:0] p;
    logic signed [31:0] q;
    logic signed [31:0] r;
  } body_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem1;
    logic [REM_W-1:0]    rem2;
    logic [DIV_BITS-1:0] q1;
    logic [DIV_BITS-1:0] q2;
    logic                neg1;
    logic                neg2;
    logic                ovf1;
    logic                ovf2;
    logic [DEN_W-1:0]    dmag;
    logic signed [31:0]  p;
  } div_t;

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic signed [31:0] prt;
    logic               flag;
  } vres_t;

  // Arctangent of 2^-i as a fraction of a full turn, scaled by 2^32.
  function automatic logic signed [32:0] step_angle(input int i);
    logic signed [32:0] a;
    case (i)
      0: a = 33'sh20000000;   1: a = 33'sh12E4051E;   2: a = 33'sh09FB385B;
      3: a = 33'sh051111D4;   4: a = 33'sh028B0D43;   5: a = 33'sh0145D7E1;
      6: a = 33'sh00A2F61E;   7: a = 33'sh00517C55;   8: a = 33'sh0028BE53;
      9: a = 33'sh00145F2F;   10: a = 33'sh000A2F98;  11: a = 33'sh000517CC;
      12: a = 33'sh00028BE6;  13: a = 33'sh000145F3;  14: a = 33'sh0000A2FA;
      15: a = 33'sh0000517D;  16: a = 33'sh000028BE;  17: a = 33'sh0000145F;
      18: a = 33'sh00000A30;  19: a = 33'sh00000518;  20: a = 33'sh0000028C;
      21: a = 33'sh00000146;  22: a = 33'sh000000A3;  23: a = 33'sh00000051;
      24: a = 33'sh00000029;  25: a = 33'sh00000014;  26: a = 33'sh0000000A;
      27: a = 33'sh00000005;  28: a = 33'sh00000003;  29: a = 33'sh00000001;
      default: a = 33'sh0;
    endcase
    return a;
  endfunction

  // One CORDIC rotation; arithmetic shifts round toward minus infinity.
  function automatic cord_t cord_step(input cord_t c, input int i);
    cord_t n;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    dx = c.x >>> i;
    dy = c.y >>> i;
    n.neg = c.neg;
    if (!c.z[32]) begin
      n.x = c.x - dy;
      n.y = c.y + dx;
      n.z = c.z - step_angle(i);
    end else begin
      n.x = c.x + dy;
      n.y = c.y - dx;
      n.z = c.z + step_angle(i);
    end
    return n;
  endfunction

  // Product with a Q2.30 factor, rounded half up to the integer scale.
  function automatic logic signed [41:0] rnd(input logic signed [71:0] pr);
    logic signed [71:0] t;
    t = pr + 72'sd536870912;
    return t[71:30];
  endfunction

  // Clip to the signed 32-bit range; the top bit reports a clip.
  function automatic logic [32:0] clip(input logic signed [47:0] v);
    logic [32:0] res;
    if (v > 48'sd2147483647) begin
      res = {1'b1, 32'h7FFFFFFF};
    end else if (v < -48'sd2147483648) begin
      res = {1'b1, 32'h80000000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/rigid_body_kinematics_core.sv */
// Z-Y-X Euler kinematics: one attitude sample in, one result out. The core takes
// a beat on every cycle that start is high (busy is always low) and presents the
// matching result for one cycle with done, in order. The core is built from three
// parallel 30-stage CORDIC pipelines, three multiply stages and a 34-stage restoring
// divider for the tan and secant terms. There is no backpressure: results must be
// taken in the cycle that done is high.
module rigid_body_kinematics_core #(
  parameter int ANGLE_BITS = rbk_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ANGLE_BITS-1:0] roll_angle,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle,
  input  logic signed [31:0]           fwd_velocity,
  input  logic signed [31:0]           side_velocity,
  input  logic signed [31:0]           down_velocity,
  input  logic signed [31:0]           roll_rate,
  input  logic signed [31:0]           pitch_rate,
  input  logic signed [31:0]           yaw_rate,
  output logic                         done,
  output logic signed [31:0]           earth_x_rate,
  output logic signed [31:0]           earth_y_rate,
  output logic signed [31:0]           earth_z_rate,
  output logic signed [31:0]           roll_angle_rate,
  output logic signed [31:0]           pitch_angle_rate,
  output logic signed [31:0]           yaw_angle_rate,
  output logic                         saturated
);

  localparam int STEPS = rbk_pkg::CORDIC_STEPS;
  localparam int DB = rbk_pkg::DIV_BITS;

  assign busy = 1'b0;

  // Fold each angle into [-90, 90) degrees and seed its CORDIC vector.
  rbk_pkg::cord_t seed [3];
  always_comb begin
    logic [ANGLE_BITS-1:0] ang [3];
    logic [31:0] ph;
    ang[0] = roll_angle;
    ang[1] = pitch_angle;
    ang[2] = yaw_angle;
    for (int a = 0; a < 3; a++) begin
      ph = {ang[a], {(32 - ANGLE_BITS){1'b0}}};
      seed[a].neg = ph[31] ^ ph[30];
      if (seed[a].neg) begin
        ph[31] = ~ph[31];
      end
      seed[a].x = rbk_pkg::CORDIC_GAIN;
      seed[a].y = '0;
      seed[a].z = {ph[31], ph};
    end
  end

  // CORDIC pipeline with the body vectors riding alongside.
  rbk_pkg::cord_t cs [STEPS+1][3];
  rbk_pkg::body_t bd [STEPS+1];
  logic           cv [STEPS+1];

  always_ff @(posedge clk) begin
    cs[0] <= seed;
    bd[0] <= '{u: fwd_velocity, v: side_velocity, w: down_velocity,
               p: roll_rate, q: pitch_rate, r: yaw_rate};
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= start;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      for (int a = 0; a < 3; a++) begin
        cs[i+1][a] <= rbk_pkg::cord_step(cs[i][a], i);
      end
      bd[i+1] <= bd[i];
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
    end
  end

  // Undo the fold to get the sine and cosine of each angle.
  logic signed [33:0] sph, cph, sth, cth, sps, cps;
  rbk_pkg::body_t     tb;
  logic               tv;
  always_ff @(posedge clk) begin
    sph <= cs[STEPS][0].neg ? -cs[STEPS][0].y : cs[STEPS][0].y;
    cph <= cs[STEPS][0].neg ? -cs[STEPS][0].x : cs[STEPS][0].x;
    sth <= cs[STEPS][1].neg ? -cs[STEPS][1].y : cs[STEPS][1].y;
    cth <= cs[STEPS][1].neg ? -cs[STEPS][1].x : cs[STEPS][1].x;
    sps <= cs[STEPS][2].neg ? -cs[STEPS][2].y : cs[STEPS][2].y;
    cps <= cs[STEPS][2].neg ? -cs[STEPS][2].x : cs[STEPS][2].x;
    tb  <= bd[STEPS];
    if (rst) begin
      tv <= 1'b0;
    end else begin
      tv <= cv[STEPS];
    end
  end

  // First products: roll rotation of v, w and of q, r.
  logic signed [65:0] m1_vc, m1_ws, m1_vs, m1_wc, m1_qs, m1_rc, m1_qc, m1_rs;
  logic signed [31:0] m1_u, m1_p;
  logic signed [33:0] m1_sth, m1_cth, m1_sps, m1_cps;
  logic               m1v;
  always_ff @(posedge clk) begin
    m1_vc  <= 66'(tb.v) * 66'(cph);
    m1_ws  <= 66'(tb.w) * 66'(sph);
    m1_vs  <= 66'(tb.v) * 66'(sph);
    m1_wc  <= 66'(tb.w) * 66'(cph);
    m1_qs  <= 66'(tb.q) * 66'(sph);
    m1_rc  <= 66'(tb.r) * 66'(cph);
    m1_qc  <= 66'(tb.q) * 66'(cph);
    m1_rs  <= 66'(tb.r) * 66'(sph);
    m1_u   <= tb.u;
    m1_p   <= tb.p;
    m1_sth <= sth;
    m1_cth <= cth;
    m1_sps <= sps;
    m1_cps <= cps;
    if (rst) begin
      m1v <= 1'b0;
    end else begin
      m1v <= tv;
    end
  end

  // Round and sum the first products.
  logic signed [33:0] m2_b, m2_c, m2_s, m2_prt;
  logic signed [31:0] m2_u, m2_p;
  logic signed [33:0] m2_sth, m2_cth, m2_sps, m2_cps;
  logic               m2v;
  always_ff @(posedge clk) begin
    m2_b   <= 34'(rbk_pkg::rnd(72'(m1_vc)) - rbk_pkg::rnd(72'(m1_ws)));
    m2_c   <= 34'(rbk_pkg::rnd(72'(m1_vs)) + rbk_pkg::rnd(72'(m1_wc)));
    m2_s   <= 34'(rbk_pkg::rnd(72'(m1_qs)) + rbk_pkg::rnd(72'(m1_rc)));
    m2_prt <= 34'(rbk_pkg::rnd(72'(m1_qc)) - rbk_pkg::rnd(72'(m1_rs)));
    m2_u   <= m1_u;
    m2_p   <= m1_p;
    m2_sth <= m1_sth;
    m2_cth <= m1_cth;
    m2_sps <= m1_sps;
    m2_cps <= m1_cps;
    if (rst) begin
      m2v <= 1'b0;
    end else begin
      m2v <= m1v;
    end
  end

  // Pitch rotation products and the roll rate numerator.
  logic signed [67:0] m3_uc, m3_cs, m3_cc, m3_us, m3_ns;
  logic signed [33:0] m3_s, m3_b, m3_prt, m3_cth, m3_sps, m3_cps;
  logic signed [31:0] m3_p;
  logic               m3v;
  always_ff @(posedge clk) begin
    m3_uc  <= 68'(m2_u) * 68'(m2_cth);
    m3_cs  <= 68'(m2_c) * 68'(m2_sth);
    m3_cc  <= 68'(m2_c) * 68'(m2_cth);
    m3_us  <= 68'(m2_u) * 68'(m2_sth);
    m3_ns  <= 68'(m2_s) * 68'(m2_sth);
    m3_s   <= m2_s;
    m3_b   <= m2_b;
    m3_prt <= m2_prt;
    m3_cth <= m2_cth;
    m3_sps <= m2_sps;
    m3_cps <= m2_cps;
    m3_p   <= m2_p;
    if (rst) begin
      m3v <= 1'b0;
    end else begin
      m3v <= m2v;
    end
  end

  // Velocity path: d and f, then the yaw rotation, then clipping.
  logic signed [35:0] m4_d, m4_f;
  logic signed [33:0] m4_b, m4_prt, m4_sps, m4_cps;
  logic signed [69:0] m5_dc, m5_bs, m5_ds, m5_bc;
  logic signed [35:0] m5_f;
  logic signed [33:0] m5_prt;
  rbk_pkg::vres_t     vd [DB-1];
  always_ff @(posedge clk) begin
    logic [32:0] k0, k1, k2, k3;
    m4_d   <= 36'(rbk_pkg::rnd(72'(m3_uc)) + rbk_pkg::rnd(72'(m3_cs)));
    m4_f   <= 36'(rbk_pkg::rnd(72'(m3_cc)) - rbk_pkg::rnd(72'(m3_us)));
    m4_b   <= m3_b;
    m4_prt <= m3_prt;
    m4_sps <= m3_sps;
    m4_cps <= m3_cps;
    m5_dc  <= 70'(m4_d) * 70'(m4_cps);
    m5_bs  <= 70'(m4_b) * 70'(m4_sps);
    m5_ds  <= 70'(m4_d) * 70'(m4_sps);
    m5_bc  <= 70'(m4_b) * 70'(m4_cps);
    m5_f   <= m4_f;
    m5_prt <= m4_prt;
    k0 = rbk_pkg::clip(48'(rbk_pkg::rnd(72'(m5_dc)) - rbk_pkg::rnd(72'(m5_bs))));
    k1 = rbk_pkg::clip(48'(rbk_pkg::rnd(72'(m5_ds)) + rbk_pkg::rnd(72'(m5_bc))));
    k2 = rbk_pkg::clip(48'(m5_f));
    k3 = rbk_pkg::clip(48'(m5_prt));
    vd[0] <= '{ex: k0[31:0], ey: k1[31:0], ez: k2[31:0], prt: k3[31:0],
               flag: k0[32] | k1[32] | k2[32] | k3[32]};
    for (int j = 1; j < DB - 1; j++) begin
      vd[j] <= vd[j-1];
    end
  end

  // Divider entry: magnitudes, quotient signs and the overflow check.
  rbk_pkg::div_t dv [DB+1];
  logic          dvv [DB+1];
  always_ff @(posedge clk) begin
    logic signed [67:0] n2;
    logic [67:0] nm1, nm2;
    logic [rbk_pkg::DEN_W-1:0] dm;
    logic [67:0] lim;
    n2  = 68'(m3_s) <<< 30;
    nm1 = m3_ns[67] ? 68'(-m3_ns) : 68'(m3_ns);
    nm2 = n2[67] ? 68'(-n2) : 68'(n2);
    dm  = m3_cth[33] ? 33'(-m3_cth) : 33'(m3_cth);
    lim = {1'b0, dm, {DB{1'b0}}};
    dv[0].rem1 <= nm1[rbk_pkg::REM_W-1:0];
    dv[0].rem2 <= nm2[rbk_pkg::REM_W-1:0];
    dv[0].q1   <= '0;
    dv[0].q2   <= '0;
    dv[0].neg1 <= m3_ns[67] ^ m3_cth[33];
    dv[0].neg2 <= n2[67] ^ m3_cth[33];
    dv[0].ovf1 <= (nm1 >= lim) && (nm1 != '0);
    dv[0].ovf2 <= (nm2 >= lim) && (nm2 != '0);
    dv[0].dmag <= dm;
    dv[0].p    <= m3_p;
    if (rst) begin
      dvv[0] <= 1'b0;
    end else begin
      dvv[0] <= m3v;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DB; k++) begin : g_div
    localparam int BIT = DB - 1 - k;
    always_ff @(posedge clk) begin
      logic [rbk_pkg::REM_W-1:0] sd;
      rbk_pkg::div_t nx;
      sd = {{(rbk_pkg::REM_W - rbk_pkg::DEN_W){1'b0}}, dv[k].dmag} << BIT;
      nx = dv[k];
      if (nx.rem1 >= sd) begin
        nx.rem1    = nx.rem1 - sd;
        nx.q1[BIT] = 1'b1;
      end
      if (nx.rem2 >= sd) begin
        nx.rem2    = nx.rem2 - sd;
        nx.q2[BIT] = 1'b1;
      end
      dv[k+1] <= nx;
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else begin
        dvv[k+1] <= dvv[k];
      end
    end
  end

  // Signed quotients, roll rate sum and the output register.
  // A zero cosine with a zero numerator gives a zero quotient.
  always_ff @(posedge clk) begin
    logic signed [35:0] qa1, qa2;
    logic [32:0] kr, ky;
    logic dz;
    dz  = (dv[DB].dmag == '0);
    qa1 = dv[DB].ovf1 ? 36'sd1 <<< DB : (dz ? 36'sd0 : 36'({1'b0, dv[DB].q1}));
    qa2 = dv[DB].ovf2 ? 36'sd1 <<< DB : (dz ? 36'sd0 : 36'({1'b0, dv[DB].q2}));
    if (dv[DB].neg1) begin
      qa1 = -qa1;
    end
    if (dv[DB].neg2) begin
      qa2 = -qa2;
    end
    kr = rbk_pkg::clip(48'(dv[DB].p) + 48'(qa1));
    ky = rbk_pkg::clip(48'(qa2));
    earth_x_rate     <= vd[DB-2].ex;
    earth_y_rate     <= vd[DB-2].ey;
    earth_z_rate     <= vd[DB-2].ez;
    pitch_angle_rate <= vd[DB-2].prt;
    roll_angle_rate  <= kr[31:0];
    yaw_angle_rate   <= ky[31:0];
    saturated        <= vd[DB-2].flag | kr[32] | ky[32];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvv[DB];
    end
  end

endmodule

/* tb/rigid_body_kinematics_core_tb.sv */
`timescale 1ns / 100ps

module rigid_body_kinematics_core_tb;

  localparam int LATENCY = 71;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] w;
    logic signed [31:0] p;
    logic signed [31:0] q;
    logic signed [31:0] r;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic signed [31:0] roll_dot;
    logic signed [31:0] pitch_dot;
    logic signed [31:0] yaw_dot;
    logic               sat;
  } kin_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
  logic signed [31:0] fwd_velocity, side_velocity, down_velocity;
  logic signed [31:0] roll_rate, pitch_rate, yaw_rate;
  logic done;
  logic signed [31:0] earth_x_rate, earth_y_rate, earth_z_rate;
  logic signed [31:0] roll_angle_rate, pitch_angle_rate, yaw_angle_rate;
  logic saturated;

  kin_t expected_kin[$];
  int errors = 0;
  int cycles = 0;
  bit allow_gaps = 1;

  rigid_body_kinematics_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .fwd_velocity(fwd_velocity), .side_velocity(side_velocity),
    .down_velocity(down_velocity), .roll_rate(roll_rate), .pitch_rate(pitch_rate),
    .yaw_rate(yaw_rate), .done(done), .earth_x_rate(earth_x_rate),
    .earth_y_rate(earth_y_rate), .earth_z_rate(earth_z_rate),
    .roll_angle_rate(roll_angle_rate), .pitch_angle_rate(pitch_angle_rate),
    .yaw_angle_rate(yaw_angle_rate), .saturated(saturated)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Floor shift of a signed value.
  function automatic longint fshr(longint a, int s);
    return a >>> s;
  endfunction

  // CORDIC sine and cosine of a binary angle, both Q2.30.
  function automatic void trig(logic [15:0] ang, output longint sn, output longint cs);
    logic [31:0] phase;
    bit flip;
    longint x, y, z, dx, dy;
    longint atan_tab[30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
    phase = {ang, 16'h0};
    flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    if (flip) phase = phase - 32'h80000000;
    z = longint'(signed'(phase));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = y;
    cs = x;
  endfunction

  // Rounded product with a Q2.30 factor; operands stay well inside 64 bits.
  function automatic longint scale_trig(longint a, longint t);
    return fshr(a * t + (longint'(1) << 29), 30);
  endfunction

  function automatic longint quot(longint n, longint d);
    if (d == 0) return n > 0 ? (longint'(1) << 40) : (n < 0 ? -(longint'(1) << 40) : 0);
    return n / d;
  endfunction

  function automatic logic [31:0] clamp32(longint a, inout logic sat);
    if (a > 64'sd2147483647) begin
      sat = 1; return 32'h7FFFFFFF;
    end
    if (a < -64'sd2147483648) begin
      sat = 1; return 32'h80000000;
    end
    return a[31:0];
  endfunction

  // Earth velocity and Euler rates for one attitude sample.
  function automatic kin_t kinematics(sample_t smp);
    kin_t k;
    longint sph, cph, sth, cth, sps, cps, b, c, d, f, s;
    longint u, v, w, p, q, r;
    logic sat;
    sat = 0;
    u = longint'(smp.u); v = longint'(smp.v); w = longint'(smp.w);
    p = longint'(smp.p); q = longint'(smp.q); r = longint'(smp.r);
    trig(smp.roll, sph, cph);
    trig(smp.pitch, sth, cth);
    trig(smp.yaw, sps, cps);
    b = scale_trig(v, cph) - scale_trig(w, sph);
    c = scale_trig(v, sph) + scale_trig(w, cph);
    d = scale_trig(u, cth) + scale_trig(c, sth);
    f = scale_trig(c, cth) - scale_trig(u, sth);
    k.ex = clamp32(scale_trig(d, cps) - scale_trig(b, sps), sat);
    k.ey = clamp32(scale_trig(d, sps) + scale_trig(b, cps), sat);
    k.ez = clamp32(f, sat);
    s = scale_trig(q, sph) + scale_trig(r, cph);
    k.roll_dot = clamp32(p + quot(s * sth, cth), sat);
    k.pitch_dot = clamp32(scale_trig(q, cph) - scale_trig(r, sph), sat);
    k.yaw_dot = clamp32(quot(s * (longint'(1) << 30), cth), sat);
    k.sat = sat;
    return k;
  endfunction

  // Send one beat, with an optional random idle burst first.
  task automatic send_sample(sample_t smp);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1;
    roll_angle <= smp.roll; pitch_angle <= smp.pitch; yaw_angle <= smp.yaw;
    fwd_velocity <= smp.u; side_velocity <= smp.v; down_velocity <= smp.w;
    roll_rate <= smp.p; pitch_rate <= smp.q; yaw_rate <= smp.r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_kin.push_back(kinematics(smp));
  endtask

  task automatic go_idle();
    start <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'(signed'($urandom_range(0, 65535)) - 32768)
                                     : 32'($urandom_range(0, 2000000)) << 4;
      3: return signed'(32'($urandom_range(0, 'h3FFFF))) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t smp;
    smp.roll = 16'($urandom); smp.yaw = 16'($urandom);
    case ($urandom_range(0, 4))
      0: smp.pitch = 16'sh4000 + 16'(signed'($urandom_range(0, 16)) - 8);
      1: smp.pitch = 16'shC000 + 16'(signed'($urandom_range(0, 16)) - 8);
      default: smp.pitch = 16'($urandom);
    endcase
    smp.u = rand_word(); smp.v = rand_word(); smp.w = rand_word();
    smp.p = rand_word(); smp.q = rand_word(); smp.r = rand_word();
    return smp;
  endfunction

  // Extremes of every field and pitch at and around ninety degrees.
  task automatic test_directed();
    logic signed [15:0] angs[7] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh4000,
                                    16'shC000, 16'sh2000, 16'sh3FFF};
    sample_t smp;
    smp = '0;
    send_sample(smp);
    foreach (angs[i]) begin
      smp.roll = angs[i]; smp.pitch = angs[i]; smp.yaw = angs[(i + 3) % 7];
      smp.u = 32'h00010000; smp.v = -32'sh00010000; smp.w = 32'h7FFFFFFF;
      smp.p = 32'h80000000; smp.q = 32'h00020000; smp.r = 32'h00030000;
      send_sample(smp);
    end
    // Pitch at ninety degrees with a zero numerator.
    smp = '0;
    smp.pitch = 16'sh4000; smp.p = 32'h00005000;
    send_sample(smp);
    smp = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    send_sample(smp);
    smp = '{16'sh8000, 16'sh8000, 16'sh8000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 32'h80000000, 32'h80000000};
    send_sample(smp);
    smp = '{16'shFFFF, 16'shFFFF, 16'shFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
            32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
    send_sample(smp);
    go_idle();
  endtask

  task automatic test_random(int n);
    repeat (n) send_sample(rand_sample());
    go_idle();
  endtask

  // Sender holds off until the pipeline has drained, then continues.
  task automatic test_drain_pause();
    while (expected_kin.size() != 0) @(posedge clk);
    repeat (4) send_sample(rand_sample());
    go_idle();
  endtask

  // Back-to-back beats with no idle cycles.
  task automatic test_streaming(int n);
    allow_gaps = 0;
    test_random(n);
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    kin_t want;
    if (!rst && done) begin
      if (expected_kin.size() == 0) begin
        $error("result beat with no expectation");
        errors++;
      end else begin
        want = expected_kin.pop_front();
        if (earth_x_rate !== want.ex) begin
          $error("earth_x_rate exp %h got %h", want.ex, earth_x_rate); errors++;
        end
        if (earth_y_rate !== want.ey) begin
          $error("earth_y_rate exp %h got %h", want.ey, earth_y_rate); errors++;
        end
        if (earth_z_rate !== want.ez) begin
          $error("earth_z_rate exp %h got %h", want.ez, earth_z_rate); errors++;
        end
        if (roll_angle_rate !== want.roll_dot) begin
          $error("roll_angle_rate exp %h got %h", want.roll_dot, roll_angle_rate);
          errors++;
        end
        if (pitch_angle_rate !== want.pitch_dot) begin
          $error("pitch_angle_rate exp %h got %h", want.pitch_dot, pitch_angle_rate);
          errors++;
        end
        if (yaw_angle_rate !== want.yaw_dot) begin
          $error("yaw_angle_rate exp %h got %h", want.yaw_dot, yaw_angle_rate); errors++;
        end
        if (saturated !== want.sat) begin
          $error("saturated exp %b got %b", want.sat, saturated); errors++;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1;
    start = 0;
    roll_angle = 0; pitch_angle = 0; yaw_angle = 0;
    fwd_velocity = 0; side_velocity = 0; down_velocity = 0;
    roll_rate = 0; pitch_rate = 0; yaw_rate = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_drain_pause();
    test_random(300);
    test_streaming(400);
    while (expected_kin.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_kin.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
